// ===== hdl/rau_pkg.sv =====
// types, constants and helpers shared by the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int IN_W          = 32;
	localparam int MAG_W         = OPERAND_WIDTH;
	localparam int PROD_W        = 2 * MAG_W;
	localparam int FRAC_W        = 64;
	localparam int DEN_W         = 63;
	localparam int SHIFT_W       = 6;
	localparam int CNT_W         = 6;

	typedef enum logic [3:0] {
		FN_ADD = 4'd0,
		FN_SUB = 4'd1,
		FN_MUL = 4'd2,
		FN_DIV = 4'd3,
		FN_EQ  = 4'd4,
		FN_NE  = 4'd5,
		FN_LT  = 4'd6,
		FN_GT  = 4'd7,
		FN_LE  = 4'd8,
		FN_GE  = 4'd9
	} rau_func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_COMB,
		S_GCD_GO,
		S_GCD_WAIT,
		S_DIVN_GO,
		S_DIVN_WAIT,
		S_DIVD_GO,
		S_DIVD_WAIT,
		S_DONE
	} rau_state_t;

	typedef struct packed {
		logic [3:0]             func;
		logic signed [IN_W-1:0] a_num;
		logic signed [IN_W-1:0] a_den;
		logic signed [IN_W-1:0] b_num;
		logic signed [IN_W-1:0] b_den;
	} rau_req_t;

	typedef struct packed {
		logic signed [FRAC_W-1:0] res_num;
		logic [DEN_W-1:0]         res_den;
		logic                     cmp_true;
		logic                     status;
	} rau_rsp_t;

	// magnitude of the low operand bits taken as signed
	function automatic logic [MAG_W-1:0] op_mag(input logic [IN_W-1:0] v);
		logic [MAG_W-1:0] lo;
		lo = v[MAG_W-1:0];
		op_mag = lo[MAG_W-1] ? (~lo + 1'b1) : lo;
	endfunction

	function automatic logic op_sign(input logic [IN_W-1:0] v);
		op_sign = v[MAG_W-1];
	endfunction

endpackage

// ===== hdl/rau_mul.sv =====
// registered unsigned multiplier shared for all cross products
`timescale 1ns / 1ps
module rau_mul (
	input  logic                      clk,
	input  logic [rau_pkg::MAG_W-1:0]  a,
	input  logic [rau_pkg::MAG_W-1:0]  b,
	output logic [rau_pkg::PROD_W-1:0] p
);
	import rau_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = prod_q;

endmodule

// ===== hdl/rau_gcd.sv =====
// iterative binary gcd, one shift or subtract step per cycle
`timescale 1ns / 1ps
module rau_gcd (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rau_pkg::FRAC_W-1:0] x,
	input  logic [rau_pkg::FRAC_W-1:0] y,
	output logic                      done,
	output logic [rau_pkg::FRAC_W-1:0] g
);
	import rau_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [FRAC_W-1:0]  x_q;
	logic [FRAC_W-1:0]  y_q;
	logic [SHIFT_W-1:0] k_q;
	logic [FRAC_W-1:0]  g_q;
	logic [FRAC_W:0]    dxy;
	logic [FRAC_W:0]    dyx;

	assign dxy = {1'b0, x_q} - {1'b0, y_q};
	assign dyx = {1'b0, y_q} - {1'b0, x_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && x_q == y_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			k_q <= '0;
		end else if (busy_q) begin
			if (x_q == y_q) begin
				g_q <= x_q << k_q;
			end else if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (!dxy[FRAC_W]) begin
				x_q <= dxy[FRAC_W:1];
			end else begin
				y_q <= dyx[FRAC_W:1];
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

// ===== hdl/rau_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rau_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rau_pkg::FRAC_W-1:0] dividend,
	input  logic [rau_pkg::FRAC_W-1:0] divisor,
	output logic                      done,
	output logic [rau_pkg::FRAC_W-1:0] quotient
);
	import rau_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FRAC_W-1:0] rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic [FRAC_W-1:0] dsr_q;
	logic [FRAC_W:0]   sh;
	logic [FRAC_W:0]   diff;
	logic              ge;

	assign sh   = {rem_q, quo_q[FRAC_W-1]};
	assign diff = sh - {1'b0, dsr_q};
	assign ge   = sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FRAC_W-1:0] : sh[FRAC_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/rational_arith_unit.sv =====
// top level: sequencer around the shared multiplier, gcd and divider
//
// Exact arithmetic and comparison on two signed fractions a_num/a_den and
// b_num/b_den. A request word on req_data is taken when req_valid and
// req_ready are both high; one response word appears on rsp_data with
// rsp_valid and is handed over when rsp_ready is high.
// The unit handles one request at a time and req_ready is low while it works.
// Unused codes, a zero denominator and division by a zero fraction go straight
// to the response. Comparisons and zero results take three products from the
// one shared 32x32 multiplier, then a compare. Other arithmetic adds a binary
// gcd loop and two divisions of 64 quotient bits each by the gcd.
// A finished response waits in the output register; a new request is taken
// while it waits, and only the hand-over of the next response holds for it.
// Reset clears the sequencer and the response valid; nothing else is kept.
`timescale 1ns / 1ps
module rational_arith_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rau_pkg::rau_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rau_pkg::rau_rsp_t rsp_data
);
	import rau_pkg::*;

	rau_state_t state_q, state_d;

	logic [3:0]        func_q;
	logic [MAG_W-1:0]  anm_q, adm_q, bnm_q, bdm_q;
	logic              ans_q, ads_q, bns_q, bds_q;
	logic [FRAC_W-1:0] p1_q, p2_q, nmag_q, dmag_q, g_q;
	logic              neg_q;
	rau_rsp_t          pend_q, rsp_q;
	logic              rsp_valid_q;

	logic [MAG_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              gcd_start, gcd_done;
	logic [FRAC_W-1:0] gcd_g;
	logic              div_start, div_done;
	logic [FRAC_W-1:0] div_dividend, div_q;

	logic              accept, load_rsp;
	logic              early, early_err;
	logic [FRAC_W-1:0] p3;
	logic              s1, s2, dneg, nneg;
	logic [FRAC_W:0]   sum, d12, d21;
	logic [FRAC_W-1:0] nmag_c;
	logic              sl, sr, cmp_t;
	logic signed [FRAC_W:0] l_v, r_v;
	logic [FRAC_W-1:0] nsat;
	logic signed [FRAC_W-1:0] num_out;

	assign accept   = req_valid && req_ready;
	assign load_rsp = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign early_err = (op_mag(req_data.a_den) == '0) || (op_mag(req_data.b_den) == '0)
		|| (req_data.func == FN_DIV && op_mag(req_data.b_num) == '0);
	assign early = (req_data.func > FN_GE) || early_err;

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			S_MUL_A: begin
				mul_a = anm_q;
				mul_b = (func_q == FN_MUL) ? bnm_q : bdm_q;
			end
			S_MUL_B: begin
				mul_a = bnm_q;
				mul_b = adm_q;
			end
			default: begin
				mul_a = adm_q;
				mul_b = (func_q == FN_DIV) ? bnm_q : bdm_q;
			end
		endcase
	end

	rau_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	rau_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.x      (nmag_q),
		.y      (dmag_q),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	assign div_dividend = (state_q == S_DIVD_GO) ? dmag_q : nmag_q;

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// combine stage: signed sum of cross products, signed product for multiply and divide, or comparison
	assign p3 = FRAC_W'(mul_p);
	assign s1 = (func_q == FN_MUL) ? (ans_q ^ bns_q) : (ans_q ^ bds_q);
	assign s2 = (bns_q ^ ads_q) ^ (func_q == FN_SUB);
	assign dneg = (func_q == FN_DIV) ? (ads_q ^ bns_q) : (ads_q ^ bds_q);
	assign sum = {1'b0, p1_q} + {1'b0, p2_q};
	assign d12 = {1'b0, p1_q} - {1'b0, p2_q};
	assign d21 = {1'b0, p2_q} - {1'b0, p1_q};

	always_comb begin
		if (func_q == FN_MUL || func_q == FN_DIV) begin
			nmag_c = p1_q;
			nneg   = s1;
		end else if (s1 == s2) begin
			nmag_c = sum[FRAC_W-1:0];
			nneg   = s1;
		end else if (!d12[FRAC_W]) begin
			nmag_c = d12[FRAC_W-1:0];
			nneg   = s1;
		end else begin
			nmag_c = d21[FRAC_W-1:0];
			nneg   = s2;
		end
	end

	assign sl  = ans_q ^ ads_q;
	assign sr  = bns_q ^ bds_q;
	assign l_v = sl ? -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q});
	assign r_v = sr ? -$signed({1'b0, p2_q}) : $signed({1'b0, p2_q});

	always_comb begin
		case (func_q)
			FN_EQ:   cmp_t = (l_v == r_v);
			FN_NE:   cmp_t = (l_v != r_v);
			FN_LT:   cmp_t = (l_v < r_v);
			FN_GT:   cmp_t = (l_v > r_v);
			FN_LE:   cmp_t = (l_v <= r_v);
			default: cmp_t = (l_v >= r_v);
		endcase
	end

	// saturate and sign the reduced numerator
	assign nsat    = nmag_q[FRAC_W-1] ? {1'b0, {(FRAC_W-1){1'b1}}} : nmag_q;
	assign num_out = neg_q ? -$signed(nsat) : $signed(nsat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		gcd_start = 1'b0;
		div_start = 1'b0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = early ? S_DONE : S_MUL_A;
				end
			end
			S_MUL_A: state_d = S_MUL_B;
			S_MUL_B: state_d = S_MUL_C;
			S_MUL_C: state_d = S_COMB;
			S_COMB: begin
				if (func_q > FN_DIV || nmag_c == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_GCD_GO;
				end
			end
			S_GCD_GO: begin
				gcd_start = 1'b1;
				state_d   = S_GCD_WAIT;
			end
			S_GCD_WAIT: begin
				if (gcd_done) begin
					state_d = S_DIVN_GO;
				end
			end
			S_DIVN_GO: begin
				div_start = 1'b1;
				state_d   = S_DIVN_WAIT;
			end
			S_DIVN_WAIT: begin
				if (div_done) begin
					state_d = S_DIVD_GO;
				end
			end
			S_DIVD_GO: begin
				div_start = 1'b1;
				state_d   = S_DIVD_WAIT;
			end
			S_DIVD_WAIT: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req_data.func;
			anm_q  <= op_mag(req_data.a_num);
			adm_q  <= op_mag(req_data.a_den);
			bnm_q  <= op_mag(req_data.b_num);
			bdm_q  <= op_mag(req_data.b_den);
			ans_q  <= op_sign(req_data.a_num);
			ads_q  <= op_sign(req_data.a_den);
			bns_q  <= op_sign(req_data.b_num);
			bds_q  <= op_sign(req_data.b_den);
			pend_q.res_num  <= '0;
			pend_q.res_den  <= DEN_W'(1);
			pend_q.cmp_true <= 1'b0;
			pend_q.status   <= (req_data.func <= FN_GE) && early_err;
		end
		if (state_q == S_MUL_B) begin
			p1_q <= FRAC_W'(mul_p);
		end
		if (state_q == S_MUL_C) begin
			p2_q <= FRAC_W'(mul_p);
		end
		if (state_q == S_COMB) begin
			nmag_q <= nmag_c;
			dmag_q <= p3;
			neg_q  <= nneg ^ dneg;
			if (func_q > FN_DIV) begin
				pend_q.cmp_true <= cmp_t;
			end
		end
		if (state_q == S_GCD_WAIT && gcd_done) begin
			g_q <= gcd_g;
		end
		if (state_q == S_DIVN_WAIT && div_done) begin
			nmag_q <= div_q;
		end
		if (state_q == S_DIVD_WAIT && div_done) begin
			pend_q.res_num <= num_out;
			pend_q.res_den <= div_q[DEN_W-1:0];
		end
		if (load_rsp) begin
			rsp_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== bench/tb_rational_arith_unit.sv =====
// self-checking testbench for the rational arithmetic unit with a scoreboard class
`timescale 1ns / 1ps
module tb_rational_arith_unit;
	import rau_pkg::*;

	localparam logic [31:0] OP_MIN       = 32'h8000_0000;
	localparam logic [31:0] OP_MAX       = 32'h7fff_ffff;
	localparam logic [31:0] OP_ONE       = 32'h0000_0001;
	localparam logic [31:0] OP_MINUS_ONE = 32'hffff_ffff;
	localparam logic [3:0]  FN_TOP_CODE  = 4'hf;
	localparam int          RANDOM_WORDS = 1730;
	localparam int          DRAIN_CYCLES = 300;

	class rau_scoreboard;
		rau_rsp_t due_results[$];
		int       faults;

		function longint op_val(logic [IN_W-1:0] v);
			logic signed [OPERAND_WIDTH-1:0] lo;
			lo = v[OPERAND_WIDTH-1:0];
			return longint'(lo);
		endfunction

		function bit [63:0] mag64(longint x);
			bit [63:0] u;
			u = x;
			return (x < 0) ? (~u + 64'd1) : u;
		endfunction

		function rau_rsp_t rational_result(rau_req_t w);
			rau_rsp_t  r;
			longint    an, ad, bn, bd, p, q, s, l, rt;
			bit        neg, dneg, holds;
			bit [63:0] nmag, dmag, x, y, t;
			r.res_num  = '0;
			r.res_den  = 63'd1;
			r.cmp_true = 1'b0;
			r.status   = 1'b0;
			an = op_val(w.a_num);
			ad = op_val(w.a_den);
			bn = op_val(w.b_num);
			bd = op_val(w.b_den);
			if (w.func > FN_GE)
				return r;
			if (ad == 0 || bd == 0 || (w.func == FN_DIV && bn == 0)) begin
				r.status = 1'b1;
				return r;
			end
			if (w.func <= FN_DIV) begin
				case (w.func)
					FN_ADD, FN_SUB: begin
						p = an * bd;
						q = bn * ad;
						if (w.func == FN_SUB)
							q = -q;
						if (p >= 0 && q >= 0) begin
							neg  = 1'b0;
							nmag = mag64(p) + mag64(q);
						end else if (p < 0 && q < 0) begin
							neg  = 1'b1;
							nmag = mag64(p) + mag64(q);
						end else begin
							s    = p + q;
							neg  = s < 0;
							nmag = mag64(s);
						end
						dneg = (ad < 0) != (bd < 0);
						dmag = mag64(ad) * mag64(bd);
					end
					FN_MUL: begin
						nmag = mag64(an) * mag64(bn);
						neg  = (an < 0) != (bn < 0);
						dmag = mag64(ad) * mag64(bd);
						dneg = (ad < 0) != (bd < 0);
					end
					default: begin
						nmag = mag64(an) * mag64(bd);
						neg  = (an < 0) != (bd < 0);
						dmag = mag64(ad) * mag64(bn);
						dneg = (ad < 0) != (bn < 0);
					end
				endcase
				if (nmag == 0)
					return r;
				x = nmag;
				y = dmag;
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				nmag = nmag / x;
				dmag = dmag / x;
				if (nmag > 64'h7fff_ffff_ffff_ffff)
					nmag = 64'h7fff_ffff_ffff_ffff;
				r.res_num = (neg != dneg) ? (~nmag + 64'd1) : nmag;
				r.res_den = dmag[62:0];
				return r;
			end
			// comparisons on cross products with positive denominators
			if (ad < 0) begin
				an = -an;
				ad = -ad;
			end
			if (bd < 0) begin
				bn = -bn;
				bd = -bd;
			end
			l  = an * bd;
			rt = bn * ad;
			case (w.func)
				FN_EQ:   holds = l == rt;
				FN_NE:   holds = l != rt;
				FN_LT:   holds = l < rt;
				FN_GT:   holds = l > rt;
				FN_LE:   holds = l <= rt;
				default: holds = l >= rt;
			endcase
			r.cmp_true = holds;
			return r;
		endfunction

		function void log_fault(string what);
			faults++;
			if (faults <= 10)
				$display("%s", what);
		endfunction

		function void note_request(rau_req_t w);
			due_results.push_back(rational_result(w));
		endfunction

		function void check_response(rau_rsp_t got);
			rau_rsp_t want;
			if (due_results.size() == 0) begin
				log_fault($sformatf("unexpected word: num %0d den %0d cmp %0b st %0b",
					got.res_num, got.res_den, got.cmp_true, got.status));
				return;
			end
			want = due_results.pop_front();
			if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
				got.cmp_true !== want.cmp_true || got.status !== want.status)
				log_fault($sformatf({"mismatch: want num %0d den %0d cmp %0b st %0b, ",
					"got num %0d den %0d cmp %0b st %0b"},
					want.res_num, want.res_den, want.cmp_true, want.status,
					got.res_num, got.res_den, got.cmp_true, got.status));
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	rau_req_t      req_data;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	rau_rsp_t      rsp_data;
	bit            calm = 1'b0;
	rau_scoreboard sb;

	rational_arith_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	always #10 clk = ~clk;

	function automatic rau_req_t make_word(logic [3:0] fn, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		rau_req_t w;
		w.func  = fn;
		w.a_num = an;
		w.a_den = ad;
		w.b_num = bn;
		w.b_den = bd;
		return w;
	endfunction

	function automatic logic [31:0] pick_operand();
		int v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0:       return OP_MIN;
					1:       return OP_MAX;
					2:       return OP_ONE;
					default: return OP_MINUS_ONE;
				endcase
			end
			1, 2, 3: v = $urandom_range(0, 40);
			4, 5:    v = $urandom_range(0, 65535);
			default: return $urandom();
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic send_word(input rau_req_t w);
		while (!calm && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(w);
		@(negedge clk);
	endtask

	// response side: random back-pressure
	always @(negedge clk)
		rsp_ready <= calm || ($urandom_range(0, 99) >= 33);

	always @(posedge clk)
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(rsp_data);

	initial begin
		#60_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		rau_req_t   w;
		logic [3:0] fn;
		int         base_n, base_d, k1, k2;
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_data  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(make_word(FN_ADD, 1, 2, 1, 3));
		send_word(make_word(FN_SUB, 1, 2, 2, 4));
		send_word(make_word(FN_MUL, -2, 3, 3, -4));
		send_word(make_word(FN_DIV, 1, 2, -1, 4));
		send_word(make_word(FN_DIV, 5, 7, 0, 3));
		send_word(make_word(FN_ADD, 1, 0, 1, 3));
		send_word(make_word(FN_EQ, 1, 2, 1, 0));
		send_word(make_word(FN_EQ, 1, 2, 2, 4));
		send_word(make_word(FN_EQ, -1, -2, 1, 2));
		send_word(make_word(FN_NE, 3, 5, 6, 10));
		send_word(make_word(FN_LT, -1, 3, 1, -4));
		send_word(make_word(FN_GT, 2, 3, 3, 5));
		send_word(make_word(FN_LE, 4, 8, 1, 2));
		send_word(make_word(FN_GE, 4, 8, 1, 2));
		send_word(make_word(FN_GE, 1, 3, 1, 2));
		send_word(make_word(FN_MUL, 0, 5, 7, 9));
		send_word(make_word(FN_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN));
		send_word(make_word(FN_MUL, OP_MAX, OP_ONE, OP_MAX, OP_ONE));
		send_word(make_word(FN_SUB, OP_MIN, OP_ONE, OP_MAX, OP_ONE));
		send_word(make_word(FN_DIV, OP_MIN, OP_MAX, OP_MAX, OP_MIN));
		send_word(make_word(FN_LT, OP_MIN, OP_ONE, OP_MAX, OP_MINUS_ONE));
		send_word(make_word(FN_MUL, OP_MINUS_ONE, OP_MIN, OP_MIN, OP_MAX));
		send_word(make_word(4'(FN_GE + 1), 1, 2, 3, 4));
		send_word(make_word(FN_TOP_CODE, OP_MIN, 0, OP_MAX, 0));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 500 && i < 800);
			if ($urandom_range(0, 59) == 0)
				fn = 4'($urandom_range(FN_GE + 1, FN_TOP_CODE));
			else
				fn = 4'($urandom_range(FN_ADD, FN_GE));
			if ($urandom_range(0, 99) < 15) begin
				// equal fractions in different scalings
				base_n = $urandom_range(0, 1000);
				base_d = $urandom_range(1, 1000);
				k1     = $urandom_range(1, 40000);
				k2     = $urandom_range(1, 40000);
				if ($urandom_range(0, 1))
					base_n = -base_n;
				if ($urandom_range(0, 1))
					k1 = -k1;
				if ($urandom_range(0, 1))
					k2 = -k2;
				w = make_word(fn, base_n * k1, base_d * k1, base_n * k2, base_d * k2);
			end else begin
				w = make_word(fn, pick_operand(), pick_operand(), pick_operand(),
					pick_operand());
			end
			send_word(w);
		end
		calm      = 1'b0;
		req_valid <= 1'b0;

		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== rational_arith_unit.f =====
hdl/rau_pkg.sv
hdl/rau_mul.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rational_arith_unit.sv
bench/tb_rational_arith_unit.sv
